>>> rtl/bop_pkg.sv
// ----------------------------------------------------------------------------
// bop_pkg
// shared types and constants of the barrier option payoff unit
// ----------------------------------------------------------------------------
package bop_pkg;

  localparam int unsigned CfgAddrWidth = 3;

  localparam logic [CfgAddrWidth-1:0] CFG_KNOCK_MODE        = 3'd0;
  localparam logic [CfgAddrWidth-1:0] CFG_BARRIER_DIRECTION = 3'd1;
  localparam logic [CfgAddrWidth-1:0] CFG_IS_CALL           = 3'd2;
  localparam logic [CfgAddrWidth-1:0] CFG_STRIKE_PRICE      = 3'd3;
  localparam logic [CfgAddrWidth-1:0] CFG_BARRIER_LEVEL     = 3'd4;

  typedef struct packed {
    logic accept;
    logic start;
    logic mul_step;
    logic set_sat;
    logic div_step;
    logic out_direct;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_calc;
    logic ovf;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/bop_ctrl.sv
// ----------------------------------------------------------------------------
// bop_ctrl
// sequencer for sample acceptance, shift-add multiply and restoring divide
// ----------------------------------------------------------------------------
module bop_ctrl #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  input  logic          s_axis_tlast_i,
  input  bop_pkg::sts_t sts_i,
  output bop_pkg::cmd_t cmd_o,
  output logic          s_axis_tready_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH);
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(VALUE_WIDTH - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  assign s_axis_tready_o = (state_q == ST_IDLE) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i && sts_i.out_free) begin
          cmd_o.accept = 1'b1;
          if (sts_i.need_calc) begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            state_d     = ST_MUL;
          end else if (s_axis_tlast_i) begin
            cmd_o.out_direct = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        cnt_d = '0;
        if (sts_i.ovf) begin
          cmd_o.set_sat = 1'b1;
          state_d       = ST_DONE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> rtl/bop_datapath.sv
// ----------------------------------------------------------------------------
// bop_datapath
// config registers, barrier tracking, shared multiply/divide register pair
// and output register
// ----------------------------------------------------------------------------
module bop_datapath #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bop_pkg::cmd_t                     cmd_i,
  output bop_pkg::sts_t                     sts_o,
  input  logic                              cfg_we_i,
  input  logic [bop_pkg::CfgAddrWidth-1:0]  cfg_addr_i,
  input  logic [VALUE_WIDTH-1:0]            cfg_wdata_i,
  input  logic [VALUE_WIDTH-1:0]            asset_price_i,
  input  logic [VALUE_WIDTH-1:0]            numeraire_value_i,
  input  logic [VALUE_WIDTH-1:0]            start_numeraire_i,
  input  logic                              first_sample_i,
  input  logic                              last_sample_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [VALUE_WIDTH-1:0]            discounted_payoff_o,
  output logic                              barrier_touched_o,
  output logic                              saturated_o
);

  localparam int unsigned W = VALUE_WIDTH;

  logic         knock_mode_q, barrier_direction_q, is_call_q;
  logic [W-1:0] strike_price_q, barrier_level_q;

  logic         touched_q, touched_d;
  logic [W-1:0] start_num_q, start_num_d;

  logic [W-1:0] mcand_q, mcand_d;
  logic [W-1:0] divisor_q, divisor_d;
  logic [W-1:0] acc_hi_q, acc_hi_d;
  logic [W-1:0] acc_lo_q, acc_lo_d;
  logic         res_touched_q, res_touched_d;
  logic         sat_q, sat_d;

  logic         out_valid_q, out_valid_d;
  logic [W-1:0] payoff_q, payoff_d;
  logic         out_touched_q, out_touched_d;
  logic         out_sat_q, out_sat_d;

  logic         hit, touched, pays, numer_zero, out_free;
  logic [W-1:0] eff_start, intr;
  logic [W:0]   mul_sum, rem, diff;
  logic         ge;

  // barrier check and path bookkeeping
  always_comb begin
    hit       = barrier_direction_q ? (asset_price_i >= barrier_level_q)
                                    : (asset_price_i <= barrier_level_q);
    touched   = (touched_q && !first_sample_i) || hit;
    eff_start = first_sample_i ? start_numeraire_i : start_num_q;
    pays      = knock_mode_q ? touched : !touched;
    numer_zero = (numeraire_value_i == '0);
    if (is_call_q) begin
      intr = (asset_price_i > strike_price_q) ? asset_price_i - strike_price_q : '0;
    end else begin
      intr = (strike_price_q > asset_price_i) ? strike_price_q - asset_price_i : '0;
    end
  end

  // shift-add multiply and restoring divide on one register pair
  assign mul_sum = {1'b0, acc_hi_q} + (acc_lo_q[0] ? {1'b0, mcand_q} : '0);
  assign rem     = {acc_hi_q, acc_lo_q[W-1]};
  assign ge      = rem >= {1'b0, divisor_q};
  assign diff    = rem - {1'b0, divisor_q};

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.need_calc = last_sample_i && pays && !numer_zero;
  assign sts_o.ovf       = acc_hi_q >= divisor_q;
  assign sts_o.out_free  = out_free;

  always_comb begin
    touched_d     = touched_q;
    start_num_d   = start_num_q;
    mcand_d       = mcand_q;
    divisor_d     = divisor_q;
    acc_hi_d      = acc_hi_q;
    acc_lo_d      = acc_lo_q;
    res_touched_d = res_touched_q;
    sat_d         = sat_q;
    out_valid_d   = out_ready_i ? 1'b0 : out_valid_q;
    payoff_d      = payoff_q;
    out_touched_d = out_touched_q;
    out_sat_d     = out_sat_q;

    if (cmd_i.accept) begin
      touched_d   = last_sample_i ? 1'b0 : touched;
      start_num_d = eff_start;
    end
    if (cmd_i.start) begin
      mcand_d       = eff_start;
      divisor_d     = numeraire_value_i;
      acc_hi_d      = '0;
      acc_lo_d      = intr;
      res_touched_d = touched;
      sat_d         = 1'b0;
    end
    if (cmd_i.mul_step) begin
      acc_hi_d = mul_sum[W:1];
      acc_lo_d = {mul_sum[0], acc_lo_q[W-1:1]};
    end
    if (cmd_i.set_sat) begin
      sat_d = 1'b1;
    end
    if (cmd_i.div_step) begin
      acc_hi_d = ge ? diff[W-1:0] : rem[W-1:0];
      acc_lo_d = {acc_lo_q[W-2:0], ge};
    end
    if (cmd_i.out_direct) begin
      // no division: zero payoff, or saturation on a zero final numeraire
      out_valid_d   = 1'b1;
      payoff_d      = (pays && numer_zero) ? '1 : '0;
      out_touched_d = touched;
      out_sat_d     = pays && numer_zero;
    end
    if (cmd_i.out_load) begin
      out_valid_d   = 1'b1;
      payoff_d      = sat_q ? '1 : acc_lo_q;
      out_touched_d = res_touched_q;
      out_sat_d     = sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knock_mode_q        <= 1'b0;
      barrier_direction_q <= 1'b0;
      is_call_q           <= 1'b1;
      strike_price_q      <= '0;
      barrier_level_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bop_pkg::CFG_KNOCK_MODE:        knock_mode_q        <= cfg_wdata_i[0];
        bop_pkg::CFG_BARRIER_DIRECTION: barrier_direction_q <= cfg_wdata_i[0];
        bop_pkg::CFG_IS_CALL:           is_call_q           <= cfg_wdata_i[0];
        bop_pkg::CFG_STRIKE_PRICE:      strike_price_q      <= cfg_wdata_i;
        bop_pkg::CFG_BARRIER_LEVEL:     barrier_level_q     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q   <= 1'b0;
      start_num_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      touched_q   <= touched_d;
      start_num_q <= start_num_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q       <= mcand_d;
    divisor_q     <= divisor_d;
    acc_hi_q      <= acc_hi_d;
    acc_lo_q      <= acc_lo_d;
    res_touched_q <= res_touched_d;
    sat_q         <= sat_d;
    payoff_q      <= payoff_d;
    out_touched_q <= out_touched_d;
    out_sat_q     <= out_sat_d;
  end

  assign out_valid_o         = out_valid_q;
  assign discounted_payoff_o = payoff_q;
  assign barrier_touched_o   = out_touched_q;
  assign saturated_o         = out_sat_q;

endmodule

>>> rtl/barrier_option_payoff_unit.sv
// ----------------------------------------------------------------------------
// barrier_option_payoff_unit
// discounted payoff of a discretely monitored barrier option, one path
// sample per transaction
// ----------------------------------------------------------------------------
// a sample that is not the last of its path is accepted while the unit is idle and the
// output register is free; a last sample that pays with a nonzero numeraire runs the
// shift-add multiplier and restoring divider, and no new sample is accepted until its
// result is loaded; the divide is skipped when the quotient overflows
// other last samples give their result in the cycle after the transaction
// reset: config to knock-out, down, call, zero strike/level; path state and output valid clear
module barrier_option_payoff_unit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [bop_pkg::CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [VALUE_WIDTH-1:0]           cfg_wdata_i,
  // samples
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // asset_price, numeraire_value, start_numeraire
  input  logic [((3*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // first_sample
  input  logic                             s_axis_tuser_i,
  input  logic                             s_axis_tlast_i,
  // results
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // discounted_payoff
  output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // barrier_touched, saturated
  output logic [1:0]                       m_axis_tuser_o
);

  localparam int unsigned W = VALUE_WIDTH;

  bop_pkg::cmd_t cmd;
  bop_pkg::sts_t sts;
  logic [W-1:0]  payoff;
  logic          touched, sat;

  bop_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .sts_i           (sts),
    .cmd_o           (cmd),
    .s_axis_tready_o (s_axis_tready_o)
  );

  bop_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_addr_i          (cfg_addr_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .asset_price_i       (s_axis_tdata_i[W-1:0]),
    .numeraire_value_i   (s_axis_tdata_i[2*W-1:W]),
    .start_numeraire_i   (s_axis_tdata_i[3*W-1:2*W]),
    .first_sample_i      (s_axis_tuser_i),
    .last_sample_i       (s_axis_tlast_i),
    .out_ready_i         (m_axis_tready_i),
    .out_valid_o         (m_axis_tvalid_o),
    .discounted_payoff_o (payoff),
    .barrier_touched_o   (touched),
    .saturated_o         (sat)
  );

  always_comb begin
    m_axis_tdata_o        = '0;
    m_axis_tdata_o[W-1:0] = payoff;
  end

  assign m_axis_tuser_o = {sat, touched};

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the barrier option payoff unit: path samples are
// streamed in under several option settings and idle patterns, a local model
// predicts each discounted payoff, and every result transaction is compared
// against it in order
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned LongHold     = 300;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainCycles  = 100;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseItems   = 72;

  typedef struct packed {
    logic [31:0] price;
    logic [31:0] numer;
    logic [31:0] start;
    logic        first;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic [31:0] payoff;
    logic        touched;
    logic        sat;
  } payoff_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                             cfg_we_i    = 1'b0;
  logic [bop_pkg::CfgAddrWidth-1:0] cfg_addr_i  = '0;
  logic [31:0]                      cfg_wdata_i = '0;

  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // asset_price, numeraire_value, start_numeraire
  logic [95:0] s_axis_tdata_i  = '0;
  // first_sample
  logic        s_axis_tuser_i  = 1'b0;
  logic        s_axis_tlast_i  = 1'b0;

  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // discounted_payoff
  logic [31:0] m_axis_tdata_o;
  // barrier_touched, saturated
  logic [1:0]  m_axis_tuser_o;

  barrier_option_payoff_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  // option settings and path state mirrored on the bench side
  logic        opt_knock_in = 1'b0;
  logic        opt_up       = 1'b0;
  logic        opt_call     = 1'b1;
  logic [31:0] opt_strike   = '0;
  logic [31:0] opt_level    = '0;
  logic        path_touched = 1'b0;
  logic [31:0] path_start   = '0;

  sample_t sample_q[$];
  payoff_t payoff_q[$];
  sample_t cur_sample;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;

  task automatic price_sample(input sample_t s);
    logic        hit;
    logic        pays;
    logic [31:0] intr;
    logic [63:0] prod;
    logic [63:0] quo;
    payoff_t     r;
    hit = opt_up ? (s.price >= opt_level) : (s.price <= opt_level);
    if (s.first) begin
      path_start   = s.start;
      path_touched = 1'b0;
    end
    path_touched = path_touched | hit;
    if (s.last) begin
      r = '0;
      r.touched = path_touched;
      pays = opt_knock_in ? path_touched : !path_touched;
      if (pays) begin
        if (opt_call) intr = (s.price > opt_strike) ? s.price - opt_strike : '0;
        else intr = (opt_strike > s.price) ? opt_strike - s.price : '0;
        if (s.numer == '0) begin
          r.payoff = '1;
          r.sat    = 1'b1;
        end else begin
          prod = 64'(path_start) * 64'(intr);
          quo  = prod / 64'(s.numer);
          if (quo[63:32] != '0) begin
            r.payoff = '1;
            r.sat    = 1'b1;
          end else begin
            r.payoff = quo[31:0];
          end
        end
      end
      payoff_q.insert(payoff_q.size(), r);
      path_touched = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [bop_pkg::CfgAddrWidth-1:0] addr,
                           input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    case (addr)
      bop_pkg::CFG_KNOCK_MODE:        opt_knock_in = data[0];
      bop_pkg::CFG_BARRIER_DIRECTION: opt_up       = data[0];
      bop_pkg::CFG_IS_CALL:           opt_call     = data[0];
      bop_pkg::CFG_STRIKE_PRICE:      opt_strike   = data;
      bop_pkg::CFG_BARRIER_LEVEL:     opt_level    = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid_i || payoff_q.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic sample_t mk_sample(input logic [31:0] price, input logic [31:0] numer,
                                        input logic [31:0] start, input logic first,
                                        input logic last);
    sample_t s;
    s.price = price;
    s.numer = numer;
    s.start = start;
    s.first = first;
    s.last  = last;
    return s;
  endfunction

  // price on the untouched side of the barrier when asked and possible
  function automatic logic [31:0] pick_price(input logic safe);
    int unsigned sel;
    logic [31:0] delta;
    sel = $urandom_range(99);
    if (safe && opt_up && opt_level != '0) return $urandom() % opt_level;
    if (safe && !opt_up && opt_level != '1) return opt_level + 1 + ($urandom() % (~opt_level));
    if (sel < 35) begin
      delta = $urandom_range(8);
      return opt_level + delta - 4;
    end
    if (sel < 45) return '0;
    if (sel < 55) return '1;
    if (sel < 65) return opt_strike + $urandom_range(0, 1 << 18) - (1 << 17);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_numer(input logic [31:0] start);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 6) return '0;
    if (sel < 16) return $urandom_range(1, 255);
    if (sel < 50) return start + $urandom_range(0, 1 << 16) - (1 << 15);
    return $urandom();
  endfunction

  task automatic queue_random_path();
    int unsigned len;
    int unsigned kind;
    logic        safe;
    logic [31:0] start;
    sample_t     s;
    len  = $urandom_range(1, 5);
    kind = $urandom_range(99);
    safe = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       start = '0;
      1:       start = '1;
      default: start = $urandom();
    endcase
    for (int i = 0; i < len; i++) begin
      s.price = pick_price(safe);
      s.numer = pick_numer(start);
      s.start = (i == 0) ? start : $urandom();
      if (kind < 10) begin
        s.first = 1'($urandom_range(1));
        s.last  = 1'($urandom_range(1));
      end else begin
        s.first = (i == 0) && (kind >= 16);
        s.last  = (i == len - 1);
      end
      sample_q.insert(sample_q.size(), s);
    end
  endtask

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) price_sample(cur_sample);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_sample = sample_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {cur_sample.start, cur_sample.numer, cur_sample.price};
          s_axis_tuser_i  <= cur_sample.first;
          s_axis_tlast_i  <= cur_sample.last;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack        <= hold_req;
      hold_left       <= LongHold;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    payoff_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (payoff_q.size() == 0) begin
        $error("unexpected result transaction: payoff %h", m_axis_tdata_o);
        err_cnt++;
      end else begin
        want = payoff_q.pop_front();
        if (m_axis_tdata_o !== want.payoff) begin
          $error("discounted_payoff: expected %h, got %h", want.payoff, m_axis_tdata_o);
          err_cnt++;
        end
        if (m_axis_tuser_o[0] !== want.touched) begin
          $error("barrier_touched: expected %b, got %b", want.touched, m_axis_tuser_o[0]);
          err_cnt++;
        end
        if (m_axis_tuser_o[1] !== want.sat) begin
          $error("saturated: expected %b, got %b", want.sat, m_axis_tuser_o[1]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [31:0] wd;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset option settings (knock-out, down, call)
    write_reg(bop_pkg::CFG_STRIKE_PRICE, 32'h0001_0000);
    write_reg(bop_pkg::CFG_BARRIER_LEVEL, 32'h0000_8000);
    @(negedge clk_i);
    // no first marker right after reset
    sample_q.insert(sample_q.size(),
                    mk_sample(32'h0002_0000, 32'h0001_0000, 32'h1234_5678, 1'b0, 1'b1));
    sample_q.insert(sample_q.size(), mk_sample('1, '1, '1, 1'b1, 1'b1));
    sample_q.insert(sample_q.size(), mk_sample(32'h0003_0000, '0, 32'h0001_0000, 1'b1, 1'b1));
    sample_q.insert(sample_q.size(), mk_sample('0, '0, 32'h0001_0000, 1'b1, 1'b1));
    sample_q.insert(sample_q.size(), mk_sample('1, 32'h0000_0001, '1, 1'b1, 1'b1));
    sample_q.insert(sample_q.size(),
                    mk_sample(32'h0005_0000, 32'h0001_0000, 32'h0002_0000, 1'b1, 1'b0));
    sample_q.insert(sample_q.size(), mk_sample(32'h0000_8000, 32'h0001_2000, '0, 1'b0, 1'b0));
    sample_q.insert(sample_q.size(), mk_sample(32'h0006_0000, 32'h0001_4000, '0, 1'b0, 1'b1));
    sample_q.insert(sample_q.size(),
                    mk_sample(32'h0005_0000, 32'h0001_0000, 32'h0002_0000, 1'b1, 1'b0));
    sample_q.insert(sample_q.size(), mk_sample(32'h0004_0000, 32'h0001_1000, '1, 1'b0, 1'b0));
    sample_q.insert(sample_q.size(), mk_sample(32'h0003_0000, 32'h0001_8000, '1, 1'b0, 1'b1));
    // fresh touch record without first marker
    sample_q.insert(sample_q.size(), mk_sample(32'h0000_8001, 32'h0001_0000, '1, 1'b0, 1'b0));
    sample_q.insert(sample_q.size(), mk_sample(32'h0002_0000, 32'h0000_c000, '1, 1'b0, 1'b1));
    sample_q.insert(sample_q.size(), mk_sample(32'h0001_0000, 32'h0000_0001, '1, 1'b1, 1'b1));
    sample_q.insert(sample_q.size(), mk_sample('0, 32'h0001_0000, 32'h0003_0000, 1'b1, 1'b0));
    sample_q.insert(sample_q.size(),
                    mk_sample(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 1'b1, 1'b1));
    sample_q.insert(sample_q.size(),
                    mk_sample(32'h0000_8001, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0));
    sample_q.insert(sample_q.size(), mk_sample(32'h0000_8000, 32'h0001_0000, '0, 1'b0, 1'b1));
    wait_drained();

    for (int p = 1; p < NumPhases; p++) begin
      wd = $urandom(); wd[0] = p[0];  write_reg(bop_pkg::CFG_KNOCK_MODE, wd);
      wd = $urandom(); wd[0] = p[1];  write_reg(bop_pkg::CFG_BARRIER_DIRECTION, wd);
      wd = $urandom(); wd[0] = !p[2]; write_reg(bop_pkg::CFG_IS_CALL, wd);
      case (p)
        1: begin
          write_reg(bop_pkg::CFG_STRIKE_PRICE, '1);
          write_reg(bop_pkg::CFG_BARRIER_LEVEL, '1);
        end
        2: begin
          write_reg(bop_pkg::CFG_STRIKE_PRICE, '0);
          write_reg(bop_pkg::CFG_BARRIER_LEVEL, '0);
        end
        5: begin
          write_reg(bop_pkg::CFG_STRIKE_PRICE, '1);
          write_reg(bop_pkg::CFG_BARRIER_LEVEL, '0);
        end
        default: begin
          write_reg(bop_pkg::CFG_STRIKE_PRICE, $urandom());
          write_reg(bop_pkg::CFG_BARRIER_LEVEL, $urandom());
        end
      endcase
      @(negedge clk_i);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      while (sample_q.size() < PhaseItems) queue_random_path();
      // back-pressure: a held result stalls the sample stream while samples wait
      if (p == 4) hold_req++;
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
